// File: sv/mqfsj_pkg.sv
// Shared constants, codes and types for the multi-queue FIFO with shortest-queue join.
// Used by mqfsj_scan and multi_queue_fifo_shortest_join_top; depends on nothing else.

package mqfsj_pkg;

  // Default sizes of the queue bank.
  localparam int unsigned MaxQueues  = 8;
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned WordWidth  = 32;

  // Fixed field widths of the ports.
  localparam int unsigned ReqWidth      = 2;
  localparam int unsigned SelWidth      = 3;
  localparam int unsigned DataWidth     = 32;
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned LenWidth      = 7;
  localparam int unsigned CountRegWidth = 4;
  localparam int unsigned CapRegWidth   = 7;
  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned CfgDataWidth  = 7;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] RegQueueCount    = 1'b0;
  localparam logic [CfgIndexWidth-1:0] RegQueueCapacity = 1'b1;

  // Register values after reset.
  localparam logic [CountRegWidth-1:0] ResetQueueCount    = 4'd8;
  localparam logic [CapRegWidth-1:0]   ResetQueueCapacity = 7'd64;

  typedef enum logic [ReqWidth-1:0] {
    REQ_PUSH       = 2'd0,
    REQ_POP        = 2'd1,
    REQ_PUSH_SHORT = 2'd2,
    REQ_NONE       = 2'd3
  } req_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

endpackage

// File: sv/mqfsj_scan.sv
// Sequential shortest-queue search: one fill counter compared per cycle against the best so far.
// Depends on mqfsj_pkg for the default sizes.

module mqfsj_scan #(
  parameter int unsigned MAX_QUEUES  = mqfsj_pkg::MaxQueues,
  parameter int unsigned QUEUE_DEPTH = mqfsj_pkg::QueueDepth
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [((MAX_QUEUES > 1 ? $clog2(MAX_QUEUES) : 1) + 1 > 4 ?
                 (MAX_QUEUES > 1 ? $clog2(MAX_QUEUES) : 1) + 1 : 4)-1:0] ecount_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]           cnt_i,
  output logic [(MAX_QUEUES > 1 ? $clog2(MAX_QUEUES) : 1)-1:0] idx_o,
  output logic                                       done_o,
  output logic [(MAX_QUEUES > 1 ? $clog2(MAX_QUEUES) : 1)-1:0] best_o
);

  localparam int unsigned QiW  = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int unsigned NW   = (QiW + 1 > 4) ? QiW + 1 : 4;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic            active_q;
  logic            done_q;
  logic [QiW-1:0]  idx_q;
  logic [QiW-1:0]  best_q;
  logic [CntW-1:0] bcnt_q;
  logic            last;
  logic            take;

  assign last = (NW'(idx_q) == (ecount_i - NW'(1)));
  // A strict compare keeps the lowest index on a tie.
  assign take = (idx_q == '0) || (cnt_i < bcnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      idx_q    <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      done_q   <= 1'b0;
      idx_q    <= '0;
    end else if (active_q) begin
      if (last) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end else begin
        idx_q <= idx_q + QiW'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (active_q && !start_i && take) begin
      best_q <= idx_q;
      bcnt_q <= cnt_i;
    end
  end

  assign idx_o  = idx_q;
  assign done_o = done_q;
  assign best_o = best_q;

endmodule

// File: sv/multi_queue_fifo_shortest_join_top.sv
// Top level of the bank of circular FIFOs with push, pop and join-shortest-queue requests.
// Depends on mqfsj_pkg and instantiates mqfsj_scan for the shortest-queue search.
//
// Channel   Direction  Handshake                     Payload
// in        to block   in_valid_i / in_stall_o       req_type, queue_sel, arrival_in, service_in
// out       from block out_valid_o / out_stall_i     status, queue_used, arrival_out,
//                                                    service_out, length_after, shortest_now
// cfg       to block   cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//
// A result is loaded into the output register after the execute step and the scan that follows
// it; a push to the shortest queue first runs a scan that picks its queue. The shortest-queue scan reads
// one fill counter per cycle; it runs after every request and also before a push to the
// shortest queue. The next request can be accepted in the cycle after the result is loaded,
// even while that result still waits under out_stall_i.
// Reset clears all pointers and counters at once; the entry memory needs no clearing.

module multi_queue_fifo_shortest_join_top #(
  parameter int unsigned MAX_QUEUES  = mqfsj_pkg::MaxQueues,
  parameter int unsigned QUEUE_DEPTH = mqfsj_pkg::QueueDepth,
  parameter int unsigned WORD_WIDTH  = mqfsj_pkg::WordWidth
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Request channel.
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [mqfsj_pkg::ReqWidth-1:0]        req_type_i,
  input  logic [mqfsj_pkg::SelWidth-1:0]        queue_sel_i,
  input  logic [mqfsj_pkg::DataWidth-1:0]       arrival_in_i,
  input  logic [mqfsj_pkg::DataWidth-1:0]       service_in_i,
  // Result channel.
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [mqfsj_pkg::StatusWidth-1:0]     status_o,
  output logic [mqfsj_pkg::SelWidth-1:0]        queue_used_o,
  output logic [mqfsj_pkg::DataWidth-1:0]       arrival_out_o,
  output logic [mqfsj_pkg::DataWidth-1:0]       service_out_o,
  output logic [mqfsj_pkg::LenWidth-1:0]        length_after_o,
  output logic [mqfsj_pkg::SelWidth-1:0]        shortest_now_o,
  // Configuration write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mqfsj_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [mqfsj_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  localparam int unsigned QiW      = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int unsigned NW       = (QiW + 1 > 4) ? QiW + 1 : 4;
  localparam int unsigned PtrW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CW       = (CntW > mqfsj_pkg::CapRegWidth) ? CntW :
                                     mqfsj_pkg::CapRegWidth;
  localparam int unsigned AW       = QiW + PtrW;
  localparam int unsigned MemDepth = 2 ** AW;
  localparam int unsigned EW       = 2 * WORD_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PICK = 5'b00010,
    S_EXEC = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [mqfsj_pkg::CountRegWidth-1:0] qcount_q;
  logic [mqfsj_pkg::CapRegWidth-1:0]   qcap_q;
  logic [NW-1:0]                       ecount;
  logic [CW-1:0]                       ecap;

  // Per-queue state.
  logic [PtrW-1:0] head_q [MAX_QUEUES];
  logic [PtrW-1:0] tail_q [MAX_QUEUES];
  logic [CntW-1:0] fill_q [MAX_QUEUES];

  // Entry memory: arrival word in the upper half, service word in the lower half.
  logic [EW-1:0] entry_mem [MemDepth];
  logic [EW-1:0] rdata_q;

  // Transaction being worked on.
  mqfsj_pkg::req_e           req_q;
  logic [NW-1:0]             q_q;
  logic [WORD_WIDTH-1:0]     arr_in_q;
  logic [WORD_WIDTH-1:0]     svc_in_q;

  // Result waiting for the output register.
  mqfsj_pkg::status_e               status_q;
  logic [mqfsj_pkg::SelWidth-1:0]   used_q;
  logic [mqfsj_pkg::LenWidth-1:0]   len_q;
  logic                             pop_ok_q;

  // Output register.
  logic                               out_valid_q;
  logic [mqfsj_pkg::StatusWidth-1:0]  status_out_q;
  logic [mqfsj_pkg::SelWidth-1:0]     used_out_q;
  logic [mqfsj_pkg::DataWidth-1:0]    arr_out_q;
  logic [mqfsj_pkg::DataWidth-1:0]    svc_out_q;
  logic [mqfsj_pkg::LenWidth-1:0]     len_out_q;
  logic [mqfsj_pkg::SelWidth-1:0]     short_out_q;

  // Scan unit interface.
  logic            scan_start;
  logic [QiW-1:0]  scan_idx;
  logic            scan_done;
  logic [QiW-1:0]  scan_best;
  logic [QiW-1:0]  fill_ridx;
  logic [CntW-1:0] fill_rd;

  // Decode of the request in the execute step.
  logic            in_accept;
  logic [QiW-1:0]  q_idx;
  logic            q_ok;
  logic            is_pop;
  logic            is_none;
  logic            is_empty;
  logic            is_full;
  logic            exec;
  logic            do_pop;
  logic            do_push;
  logic [PtrW-1:0] head_cur;
  logic [PtrW-1:0] tail_cur;
  logic [PtrW-1:0] head_adv;
  logic [PtrW-1:0] tail_adv;
  logic [CntW-1:0] fill_dec;
  logic [CntW-1:0] fill_inc;
  logic [CW-1:0]   len_w;
  logic            out_free;
  logic [NW-1:0]   best_w;

  // Effective register values after clamping.
  always_comb begin
    if (qcount_q == '0) begin
      ecount = NW'(1);
    end else if (NW'(qcount_q) > NW'(MAX_QUEUES)) begin
      ecount = NW'(MAX_QUEUES);
    end else begin
      ecount = NW'(qcount_q);
    end
    if (qcap_q == '0) begin
      ecap = CW'(1);
    end else if (CW'(qcap_q) > CW'(QUEUE_DEPTH)) begin
      ecap = CW'(QUEUE_DEPTH);
    end else begin
      ecap = CW'(qcap_q);
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcount_q <= mqfsj_pkg::ResetQueueCount;
      qcap_q   <= mqfsj_pkg::ResetQueueCapacity;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mqfsj_pkg::RegQueueCount:    qcount_q <= cfg_data_i[mqfsj_pkg::CountRegWidth-1:0];
        mqfsj_pkg::RegQueueCapacity: qcap_q   <= cfg_data_i[mqfsj_pkg::CapRegWidth-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign q_idx     = q_q[QiW-1:0];
  assign exec      = (state_q == S_EXEC);
  assign fill_ridx = exec ? q_idx : scan_idx;
  assign fill_rd   = fill_q[fill_ridx];
  assign head_cur  = head_q[q_idx];
  assign tail_cur  = tail_q[q_idx];

  // The clamped count never exceeds the number of queues, so one compare covers both limits.
  assign q_ok     = (q_q < ecount);
  assign is_pop   = (req_q == mqfsj_pkg::REQ_POP);
  assign is_none  = (req_q == mqfsj_pkg::REQ_NONE);
  assign is_empty = (fill_rd == '0);
  assign is_full  = (CW'(fill_rd) >= ecap);
  assign do_pop   = exec && !is_none && q_ok && is_pop && !is_empty;
  assign do_push  = exec && !is_none && q_ok && !is_pop && !is_full;

  // A pointer that reaches the current capacity wraps to the start.
  assign head_adv = ((CW'(head_cur) + CW'(1)) >= ecap) ? '0 : head_cur + PtrW'(1);
  assign tail_adv = ((CW'(tail_cur) + CW'(1)) >= ecap) ? '0 : tail_cur + PtrW'(1);
  assign fill_dec = fill_rd - CntW'(1);
  assign fill_inc = fill_rd + CntW'(1);

  assign scan_start = (in_accept && (req_type_i == mqfsj_pkg::REQ_PUSH_SHORT)) || exec;

  mqfsj_scan #(
    .MAX_QUEUES  (MAX_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .ecount_i (ecount),
    .cnt_i    (fill_rd),
    .idx_o    (scan_idx),
    .done_o   (scan_done),
    .best_o   (scan_best)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = (req_type_i == mqfsj_pkg::REQ_PUSH_SHORT) ? S_PICK : S_EXEC;
        end
      end
      S_PICK: begin
        if (scan_done) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_SCAN;
      S_SCAN: begin
        if (scan_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latched transaction; a push to the shortest queue gets its queue from the first scan.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q    <= mqfsj_pkg::req_e'(req_type_i);
      q_q      <= NW'(queue_sel_i);
      arr_in_q <= arrival_in_i[WORD_WIDTH-1:0];
      svc_in_q <= service_in_i[WORD_WIDTH-1:0];
    end else if (state_q == S_PICK && scan_done) begin
      q_q <= NW'(scan_best);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (do_pop) begin
      fill_q[q_idx] <= fill_dec;
      if (fill_dec == '0) begin
        head_q[q_idx] <= '0;
        tail_q[q_idx] <= '0;
      end else begin
        head_q[q_idx] <= head_adv;
      end
    end else if (do_push) begin
      tail_q[q_idx] <= tail_adv;
      fill_q[q_idx] <= fill_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_mem[{q_idx, tail_cur}] <= {arr_in_q, svc_in_q};
    end
    if (do_pop) begin
      rdata_q <= entry_mem[{q_idx, head_cur}];
    end
  end

  always_comb begin
    if (is_none || !q_ok) begin
      len_w = '0;
    end else if (is_pop) begin
      len_w = is_empty ? '0 : CW'(fill_dec);
    end else begin
      len_w = is_full ? CW'(fill_rd) : CW'(fill_inc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      pop_ok_q <= do_pop;
      len_q    <= len_w[mqfsj_pkg::LenWidth-1:0];
      used_q   <= is_none ? '0 : q_q[mqfsj_pkg::SelWidth-1:0];
      if (is_none) begin
        status_q <= mqfsj_pkg::ST_OK;
      end else if (!q_ok) begin
        status_q <= mqfsj_pkg::ST_BAD_INDEX;
      end else if (is_pop) begin
        status_q <= is_empty ? mqfsj_pkg::ST_EMPTY : mqfsj_pkg::ST_OK;
      end else begin
        status_q <= is_full ? mqfsj_pkg::ST_FULL : mqfsj_pkg::ST_OK;
      end
    end
  end

  assign best_w = NW'(scan_best);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      status_out_q <= status_q;
      used_out_q   <= used_q;
      len_out_q    <= len_q;
      short_out_q  <= best_w[mqfsj_pkg::SelWidth-1:0];
      if (pop_ok_q) begin
        arr_out_q <= mqfsj_pkg::DataWidth'(rdata_q[EW-1:WORD_WIDTH]);
        svc_out_q <= mqfsj_pkg::DataWidth'(rdata_q[WORD_WIDTH-1:0]);
      end else begin
        arr_out_q <= '0;
        svc_out_q <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_out_q;
  assign queue_used_o   = used_out_q;
  assign arrival_out_o  = arr_out_q;
  assign service_out_o  = svc_out_q;
  assign length_after_o = len_out_q;
  assign shortest_now_o = short_out_q;

endmodule
